### design/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
        logic reject_full;
        logic reject_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode opcode;
        logic    full;
        logic    empty;
    } t_dp_flags;

endpackage

### design/deq_ctrl.sv
// Controller state machine of the double-ended queue.
module deq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  deq_pkg::t_dp_flags i_flags,
    output deq_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy,
    output logic               o_result_valid
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_flags.opcode) inside
                    OP_PUSH_FRONT, OP_PUSH_REAR: begin
                        if (i_flags.full) begin
                            o_cmd.reject_full = 1'b1;
                        end else if (i_flags.opcode == OP_PUSH_FRONT) begin
                            o_cmd.push_front = 1'b1;
                        end else begin
                            o_cmd.push_rear = 1'b1;
                        end
                    end
                    default: begin
                        if (i_flags.empty) begin
                            o_cmd.reject_empty = 1'b1;
                        end else if (i_flags.opcode == OP_POP_FRONT) begin
                            o_cmd.pop_front = 1'b1;
                        end else begin
                            o_cmd.pop_rear = 1'b1;
                        end
                    end
                endcase
                n_state = S_RESP;
            end
            S_RESP: begin
                o_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/deq_dp.sv
// Datapath of the double-ended queue: entry memory, front pointer and count.
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  deq_pkg::t_dp_cmd                   i_cmd,
    input  deq_pkg::t_opcode                   i_opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]  i_push_value,
    output deq_pkg::t_dp_flags                 o_flags,
    output logic signed [deq_pkg::DATA_W-1:0]  o_popped_value,
    output deq_pkg::t_status                   o_status,
    output logic [CW-1:0]                      o_occupancy
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_word;
    t_opcode           r_op;
    t_status           r_status;
    logic              r_pop_ok;
    logic [AW-1:0]     r_front;
    logic [CW-1:0]     r_count;

    logic [CW:0]       s_sum;
    logic [CW:0]       s_sum_m1;
    logic [AW-1:0]     s_rear;
    logic [AW-1:0]     s_last;
    logic [AW-1:0]     s_front_inc;
    logic [AW-1:0]     s_front_dec;
    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic              s_re;
    logic [AW-1:0]     s_raddr;

    // Rear positions are derived from front plus count, wrapped once.
    always_comb begin
        s_sum    = (CW + 1)'(r_front) + (CW + 1)'(r_count);
        s_sum_m1 = s_sum - (CW + 1)'(1);
        s_rear   = (s_sum >= (CW + 1)'(DEPTH)) ? AW'(s_sum - (CW + 1)'(DEPTH))
                                                : AW'(s_sum);
        s_last   = (s_sum_m1 >= (CW + 1)'(DEPTH)) ? AW'(s_sum_m1 - (CW + 1)'(DEPTH))
                                                   : AW'(s_sum_m1);
        s_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
        s_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
        s_we    = i_cmd.push_front | i_cmd.push_rear;
        s_waddr = i_cmd.push_front ? s_front_dec : s_rear;
        s_re    = i_cmd.pop_front | i_cmd.pop_rear;
        s_raddr = i_cmd.pop_front ? r_front : s_last;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_waddr] <= r_word;
        end
        if (s_re) begin
            r_rd_data <= r_mem[s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_word <= i_push_value;
        end
        if (s_we || i_cmd.reject_full) begin
            r_pop_ok <= 1'b0;
        end else if (s_re) begin
            r_pop_ok <= 1'b1;
        end else if (i_cmd.reject_empty) begin
            r_pop_ok <= 1'b0;
        end
        if (i_cmd.reject_full) begin
            r_status <= ST_FULL;
        end else if (i_cmd.reject_empty) begin
            r_status <= ST_EMPTY;
        end else if (s_we || s_re) begin
            r_status <= ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push_front) begin
                r_front <= s_front_dec;
            end else if (i_cmd.pop_front) begin
                r_front <= s_front_inc;
            end
            if (s_we) begin
                r_count <= r_count + CW'(1);
            end else if (s_re) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_flags.opcode = r_op;
    assign o_flags.full   = (r_count == CW'(DEPTH));
    assign o_flags.empty  = (r_count == '0);
    assign o_popped_value = r_pop_ok ? r_rd_data : '1;
    assign o_status       = r_status;
    assign o_occupancy    = r_count;

endmodule

### design/double_ended_queue.sv
// Top level of the double-ended queue: controller plus datapath.
//
// A double-ended queue of signed 32-bit words held in a ring buffer of DEPTH
// entries. A request is taken when start is high while busy is low; it pushes
// at the front or the rear, or pops from the front or the rear. Each request
// yields exactly one result, shown for a single cycle with o_result_valid high:
// the popped word (all ones for a push or a failed pop), a status (ok, empty
// on pop, full on push) and the number of entries held afterwards. A rejected
// request leaves the queue unchanged. The receiver cannot stall, so it must
// capture the result in the cycle it is marked valid. A request is first
// captured; then the pointers are updated and the entry memory, whose read
// data is registered, is accessed; then the result is presented. Busy stays
// high until the result has been shown, and only then is a new request
// taken. No clearing pass is needed after reset.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  deq_pkg::t_opcode                   i_opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]  i_push_value,
    output logic                               o_result_valid,
    output logic signed [deq_pkg::DATA_W-1:0]  o_popped_value,
    output deq_pkg::t_status                   o_status,
    output logic [CW-1:0]                      o_occupancy
);
    import deq_pkg::*;

    t_dp_cmd   s_cmd;
    t_dp_flags s_flags;

    // The controller sequences each request and raises the result strobe.
    deq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_flags        (s_flags),
        .o_cmd          (s_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    // The datapath holds the entries, the front pointer and the count.
    deq_dp #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .i_opcode       (i_opcode),
        .i_push_value   (i_push_value),
        .o_flags        (s_flags),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

endmodule
